[design/pfs_pkg.sv]
`default_nettype none
package pfs_pkg;

  localparam int VALUE_W = 16;
  localparam int EXP_W   = 4;
  // trial divisors never pass 256: 256*256 exceeds any 16-bit value
  localparam int DIV_W   = 9;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ONE  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic [VALUE_W-1:0] prime;
    logic [EXP_W-1:0]   exponent;
    status_t            status;
    logic               last;
  } res_t;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [DIV_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quot;
    logic [DIV_W-1:0]   rem;
  } div_res_t;

endpackage
`default_nettype wire

[design/pfs_ifs.sv]
`default_nettype none
interface pfs_num_if;
  logic                         valid;
  logic                         ready;
  logic [pfs_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface pfs_factor_if;
  logic                         valid;
  logic                         ready;
  logic [pfs_pkg::VALUE_W-1:0]  prime;
  logic [pfs_pkg::EXP_W-1:0]    exponent;
  logic [1:0]                   status;
  logic                         last;

  modport source (output valid, output prime, output exponent, output status, output last,
                  input ready);
  modport sink   (input valid, input prime, input exponent, input status, input last,
                  output ready);
endinterface
`default_nettype wire

[design/pfs_mem.sv]
`default_nettype none
// 1-bit sieve table, one write port, one read port, registered read data
module pfs_mem #(
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic                     wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic                          rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/pfs_div.sv]
`default_nettype none
// restoring divider, one quotient bit per cycle
module pfs_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pfs_pkg::div_req_t req,
  output pfs_pkg::div_res_t      res
);

  localparam int CW = $clog2(pfs_pkg::VALUE_W);

  logic                          busy;
  logic [CW-1:0]                 cnt;
  logic [pfs_pkg::VALUE_W-1:0]   q;
  logic [pfs_pkg::DIV_W-1:0]     r;
  logic [pfs_pkg::DIV_W-1:0]     d;
  logic                          done;
  logic [pfs_pkg::DIV_W:0]       r_sh;
  logic                          fits;

  assign r_sh = {r, q[pfs_pkg::VALUE_W-1]};
  assign fits = (r_sh >= {1'b0, d});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(pfs_pkg::VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q <= req.dividend;
      r <= '0;
      d <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        r <= pfs_pkg::DIV_W'(r_sh - {1'b0, d});
        q <= {q[pfs_pkg::VALUE_W-2:0], 1'b1};
      end else begin
        r <= r_sh[pfs_pkg::DIV_W-1:0];
        q <= {q[pfs_pkg::VALUE_W-2:0], 1'b0};
      end
    end
  end

  assign res.done = done;
  assign res.quot = q;
  assign res.rem  = r;

endmodule
`default_nettype wire

[design/prime_factorizer_with_sieve.sv]
`default_nettype none
// Prime factorizer. After reset the block first writes the whole sieve table
// and then strikes multiples of every base i with i*i < SIEVE_DEPTH that is
// still marked prime in the table (one table write per multiple); num.ready
// stays low until that is done. Each accepted word on num is then factored
// by trial division over the table primes in ascending order, one factor
// word per distinct prime on factor, the final one marked by last. A value
// of 0 or 1 gives one word with status ZERO or ONE and prime/exponent 0. One
// value is worked on at a time. Per candidate divisor the table is read in
// S_RD and checked in S_CHK; each division runs on a bit-serial divider, so
// the time a value takes is set by the count of primes below sqrt(value)
// and the exponents found. Trial division stops once candidate^2 exceeds
// what is left or the candidate passes the table, and that leftover is
// reported as a final factor with exponent 1 (with a small table it need
// not be prime). The last factor word may sit in the output register while
// the next value is accepted.
module prime_factorizer_with_sieve #(
  parameter int SIEVE_DEPTH = 65536
) (
  input  wire logic   clk,
  input  wire logic   rst,
  pfs_num_if.sink     num,
  pfs_factor_if.source factor
);

  localparam int AW  = $clog2(SIEVE_DEPTH);
  localparam int JW  = AW + 1;      // strike index, room for overshoot
  localparam int IW  = AW / 2 + 2;  // sieve base, up to sqrt(depth)
  localparam int SQW = 2 * IW;
  localparam int VW  = pfs_pkg::VALUE_W;
  localparam int DW  = pfs_pkg::DIV_W;
  localparam int EW  = pfs_pkg::EXP_W;

  typedef enum logic [8:0] {
    S_FILL   = 9'b000000001,  // write initial table contents
    S_SV_RD  = 9'b000000010,  // read table at sieve base
    S_SV_CHK = 9'b000000100,
    S_STRIKE = 9'b000001000,  // clear multiples of the base
    S_IDLE   = 9'b000010000,
    S_RD     = 9'b000100000,  // read table at trial divisor
    S_CHK    = 9'b001000000,
    S_DIV    = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_t;

  state_t                state;
  logic [JW-1:0]         j;
  logic [IW-1:0]         si;
  logic [DW-1:0]         fi;
  logic [VW-1:0]         rem;
  logic [EW-1:0]         e;
  pfs_pkg::res_t         pend;
  pfs_pkg::res_t         ores;
  logic                  ovalid;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic                  wdata;
  logic [AW-1:0]         raddr;
  logic                  rdata;

  pfs_pkg::div_req_t     dreq;
  pfs_pkg::div_res_t     dres;

  logic [SQW-1:0]        sq;
  logic [JW-1:0]         j_step;
  logic [2*DW-1:0]       fsq;
  logic                  f_stop;
  logic                  out_load;
  logic                  num_take;

  pfs_mem #(
    .DEPTH (SIEVE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  pfs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .res (dres)
  );

  // sieve arithmetic
  assign sq     = SQW'(si) * SQW'(si);
  assign j_step = j + JW'(si);

  // trial division ends when the candidate passes the table or its square
  // exceeds what is left: the leftover is then a single factor
  assign fsq    = (2*DW)'(fi) * (2*DW)'(fi);
  assign f_stop = (32'(fi) >= 32'(SIEVE_DEPTH)) || (fsq > (2*DW)'(rem));

  // table ports
  assign we    = (state == S_FILL) || (state == S_STRIKE);
  assign waddr = j[AW-1:0];
  assign wdata = (state == S_FILL) && (j >= JW'(2));
  assign raddr = (state == S_SV_RD) ? AW'(si) : AW'(fi);

  // divider: first divide from the table hit, repeats while it divides evenly
  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = rem;
    dreq.divisor  = fi;
    if (state == S_CHK && rdata) begin
      dreq.start = 1'b1;
    end else if (state == S_DIV && dres.done && dres.rem == '0) begin
      dreq.start    = 1'b1;
      dreq.dividend = dres.quot;
    end
  end

  assign num.ready = (state == S_IDLE);
  assign num_take  = num.valid && num.ready;
  assign out_load  = (state == S_EMIT) && (!ovalid || factor.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
      j     <= '0;
    end else begin
      unique case (state)
        S_FILL: begin
          j <= j + JW'(1);
          if (j[AW-1:0] == AW'(SIEVE_DEPTH - 1)) begin
            si    <= IW'(2);
            state <= S_SV_RD;
          end
        end
        S_SV_RD: begin
          if (sq < SQW'(SIEVE_DEPTH)) begin
            state <= S_SV_CHK;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SV_CHK: begin
          if (rdata) begin
            j     <= JW'(sq);
            state <= S_STRIKE;
          end else begin
            si    <= si + IW'(1);
            state <= S_SV_RD;
          end
        end
        S_STRIKE: begin
          j <= j_step;
          if (j_step >= JW'(SIEVE_DEPTH)) begin
            si    <= si + IW'(1);
            state <= S_SV_RD;
          end
        end
        S_IDLE: begin
          if (num_take) begin
            rem <= num.value;
            fi  <= DW'(2);
            if (num.value == '0) begin
              pend  <= '{prime: '0, exponent: '0, status: pfs_pkg::ST_ZERO, last: 1'b1};
              state <= S_EMIT;
            end else if (num.value == VW'(1)) begin
              pend  <= '{prime: '0, exponent: '0, status: pfs_pkg::ST_ONE, last: 1'b1};
              state <= S_EMIT;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          if (f_stop) begin
            pend  <= '{prime: rem, exponent: EW'(1), status: pfs_pkg::ST_OK, last: 1'b1};
            state <= S_EMIT;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          e <= '0;
          if (rdata) begin
            state <= S_DIV;
          end else begin
            fi    <= fi + DW'(1);
            state <= S_RD;
          end
        end
        S_DIV: begin
          if (dres.done) begin
            if (dres.rem == '0) begin
              rem <= dres.quot;
              e   <= e + EW'(1);
            end else if (e != '0) begin
              pend  <= '{prime: VW'(fi), exponent: e, status: pfs_pkg::ST_OK,
                         last: (rem == VW'(1))};
              fi    <= fi + DW'(1);
              state <= S_EMIT;
            end else begin
              fi    <= fi + DW'(1);
              state <= S_RD;
            end
          end
        end
        S_EMIT: begin
          if (out_load) begin
            state <= pend.last ? S_IDLE : S_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (out_load) begin
      ovalid <= 1'b1;
    end else if (factor.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ores <= pend;
    end
  end

  assign factor.valid    = ovalid;
  assign factor.prime    = ores.prime;
  assign factor.exponent = ores.exponent;
  assign factor.status   = ores.status;
  assign factor.last     = ores.last;

endmodule
`default_nettype wire

[sim/tb_prime_factorizer_with_sieve.sv]
`timescale 1ns / 1ps
module tb_prime_factorizer_with_sieve;

  // Longest gap without any word accepted. It is set well above the length
  // of the sieve pass after reset, when no word is taken.
  localparam int unsigned IDLE_LIMIT  = 1000000;
  // Receiver hold-off. It is far longer than one factorization, so the block
  // fills up and drops num.ready while the sender keeps offering.
  localparam int unsigned HOLD_CYCLES = 3000;
  // Quiet time allowed after the last expected word.
  localparam int unsigned TAIL_CYCLES = 2000;
  localparam int unsigned N_RANDOM    = 97;
  localparam int unsigned IDLE_PCT    = 22;

  localparam int unsigned SMALL_PRIMES [12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
  localparam int unsigned BIG_PRIMES   [6]  = '{251, 241, 257, 32749, 65521, 65519};

  typedef struct {
    logic [pfs_pkg::VALUE_W-1:0] value;
    bit                          drain;   // wait for all due words before offering
  } pend_t;

  logic clk;
  logic rst;

  pfs_num_if    num_bus ();
  pfs_factor_if fac_bus ();

  prime_factorizer_with_sieve u_top (
    .clk    (clk),
    .rst    (rst),
    .num    (num_bus),
    .factor (fac_bus)
  );

  pend_t         values_pending [$];
  pfs_pkg::res_t factor_words_due [$];
  int unsigned   n_vals;        // values accepted on num
  int unsigned   n_popped;      // values the driver has retired
  int unsigned   n_words;       // factor words accepted
  int unsigned   n_err;
  int unsigned   n_zero_one;
  int unsigned   idle_cycles;
  int unsigned   hold_left;
  bit            hold_done;

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Expected factor words for one value: trial division by every d with
  // d*d <= what is left; only primes can divide at that point, and the
  // leftover above 1 is itself prime. Full-depth sieve, so no partial table.
  task automatic factorize_into_due(input logic [pfs_pkg::VALUE_W-1:0] v);
    int unsigned   left;
    int unsigned   d;
    int unsigned   e;
    pfs_pkg::res_t w;
    pfs_pkg::res_t found [$];
    left = v;
    if (v == 0) begin
      w = '{prime: '0, exponent: '0, status: pfs_pkg::ST_ZERO, last: 1'b1};
      found = {found, w};
      n_zero_one++;
    end else if (v == 1) begin
      w = '{prime: '0, exponent: '0, status: pfs_pkg::ST_ONE, last: 1'b1};
      found = {found, w};
      n_zero_one++;
    end else begin
      for (d = 2; d * d <= left; d++) begin
        if (left % d == 0) begin
          e = 0;
          while (left % d == 0) begin
            left = left / d;
            e++;
          end
          w = '{prime: d[pfs_pkg::VALUE_W-1:0], exponent: e[pfs_pkg::EXP_W-1:0],
                status: pfs_pkg::ST_OK, last: 1'b0};
          found = {found, w};
        end
      end
      if (left > 1) begin
        w = '{prime: left[pfs_pkg::VALUE_W-1:0], exponent: 4'd1,
              status: pfs_pkg::ST_OK, last: 1'b0};
        found = {found, w};
      end
      found[found.size() - 1].last = 1'b1;
    end
    factor_words_due = {factor_words_due, found};
  endtask

  // Random value: uniform for some picks, else structured numbers with many factors
  // or high exponents, small values, large primes or values near the top of the range.
  function automatic logic [pfs_pkg::VALUE_W-1:0] pick_value();
    int unsigned sel;
    int unsigned v;
    int unsigned p;
    int unsigned k;
    sel = $urandom_range(0, 99);
    v   = 1;
    if (sel < 40) begin
      v = $urandom_range(0, 65535);
    end else if (sel < 65) begin
      // smooth number, up to six distinct small primes
      k = $urandom_range(1, 8);
      repeat (k) begin
        p = SMALL_PRIMES[$urandom_range(0, 11)];
        if (v * p <= 65535) v = v * p;
      end
    end else if (sel < 80) begin
      // prime power, random exponent of up to 15 where it fits
      p = ($urandom_range(0, 3) == 0) ? BIG_PRIMES[$urandom_range(0, 1)]
                                       : SMALL_PRIMES[$urandom_range(0, 5)];
      k = $urandom_range(1, 15);
      repeat (k) begin
        if (v * p <= 65535) v = v * p;
      end
    end else if (sel < 88) begin
      v = $urandom_range(0, 15);
    end else if (sel < 94) begin
      // large prime, alone or doubled
      p = BIG_PRIMES[$urandom_range(0, 5)];
      v = p;
      if (p * 2 <= 65535 && $urandom_range(0, 1) == 1) v = p * 2;
    end else begin
      v = 65535 - $urandom_range(0, 255);
    end
    return v[pfs_pkg::VALUE_W-1:0];
  endfunction

  // Sampling side: check factor words against the oldest due word, then
  // predict for any value taken on num in the same cycle.
  always @(posedge clk) begin
    pfs_pkg::res_t want;
    if (!rst) begin
      if (fac_bus.valid && fac_bus.ready) begin
        n_words++;
        if (factor_words_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, got prime %0d exponent %0d %s",
                   $time, fac_bus.prime, fac_bus.exponent,
                   $sformatf("status %0d last %0d", fac_bus.status, fac_bus.last));
          n_err++;
        end else begin
          want = factor_words_due.pop_front();
          if (fac_bus.prime !== want.prime) begin
            $display("%0t: prime mismatch, expected %0d, got %0d",
                     $time, want.prime, fac_bus.prime);
            n_err++;
          end
          if (fac_bus.exponent !== want.exponent) begin
            $display("%0t: exponent mismatch, expected %0d, got %0d",
                     $time, want.exponent, fac_bus.exponent);
            n_err++;
          end
          if (fac_bus.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, fac_bus.status);
            n_err++;
          end
          if (fac_bus.last !== want.last) begin
            $display("%0t: last mismatch, expected %0d, got %0d",
                     $time, want.last, fac_bus.last);
            n_err++;
          end
        end
      end
      if (num_bus.valid && num_bus.ready) begin
        factorize_into_due(num_bus.value);
        n_vals++;
      end
    end
  end

  // Watchdog: cycles with no word accepted on either side
  always @(posedge clk) begin
    if ((num_bus.valid && num_bus.ready) || (fac_bus.valid && fac_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sender: retire the value taken at the last rising edge, then offer the
  // next one unless idling or waiting for the block to drain.
  always @(negedge clk) begin
    logic                        nxt_valid;
    logic [pfs_pkg::VALUE_W-1:0] nxt_value;
    nxt_valid = num_bus.valid;
    nxt_value = num_bus.value;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (n_popped != n_vals) begin
        values_pending.delete(0);
        n_popped++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && values_pending.size() != 0) begin
        if (values_pending[0].drain && factor_words_due.size() != 0) begin
          nxt_valid = 1'b0;
        end else if ((n_vals >= 60 && n_vals < 90) || $urandom_range(0, 99) >= IDLE_PCT) begin
          // words 60..89 go back to back
          nxt_valid = 1'b1;
          nxt_value = values_pending[0].value;
        end
      end
    end
    num_bus.valid <= nxt_valid;
    num_bus.value <= nxt_value;
  end

  // Receiver: one long hold-off once the random part is under way,
  // a stretch with ready held high, random stalls otherwise.
  always @(negedge clk) begin
    if (rst) begin
      fac_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      fac_bus.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_done && n_vals >= 30) begin
      fac_bus.ready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else if (n_words >= 100 && n_words < 180) begin
      fac_bus.ready <= 1'b1;
    end else begin
      fac_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    logic [pfs_pkg::VALUE_W-1:0] directed [$];
    pend_t                       it;
    n_vals        = 0;
    n_popped      = 0;
    n_words       = 0;
    n_err         = 0;
    n_zero_one    = 0;
    idle_cycles   = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    rst           = 1'b1;
    num_bus.valid = 1'b0;
    num_bus.value = '0;
    fac_bus.ready = 1'b0;

    // zero, one, tiny primes and prime squares, top of range, exponent 15,
    // six distinct factors, squares near the sieve bound, bit patterns
    directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd49, 16'd65535, 16'd65534,
                 16'd65521, 16'd32768, 16'd30030, 16'd65025, 16'd64009, 16'd63001,
                 16'd59049, 16'd21845, 16'd43690, 16'd256, 16'd257, 16'd65498,
                 16'd32767, 16'd0, 16'd1};
    foreach (directed[i]) begin
      it.value = directed[i];
      it.drain = 1'b0;
      values_pending = {values_pending, it};
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      it.value = pick_value();
      // sender stops until the block has emptied, at the start of the
      // random part and once more midway
      it.drain = (i == 0 || i == 48);
      values_pending = {values_pending, it};
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (values_pending.size() != 0 || num_bus.valid) @(posedge clk);
    while (factor_words_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d values (%0d of them zero or one) and %0d factor words,",
             n_vals, n_zero_one, n_words);
    $display("with prime powers, six-factor products, large primes, stalls and drains");
    if (n_err == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
